// File: rtl/core/lcs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcs_pkg - shared types and constants for the luma contrast stretch block
// Pixel and result payload structs, configuration register indexes and the
// fixed-point constants of the Q8.10 stretch.
// ----------------------------------------------------------------------------
package lcs_pkg;

	localparam int unsigned PIX_W       = 8;
	localparam int unsigned GAIN_W      = 18;
	localparam int unsigned GAIN_FRAC   = 10;
	localparam int unsigned CFG_DATA_W  = 18;
	localparam int unsigned CFG_INDEX_W = 2;

	// rounding constant of the Q.10 stretch product
	localparam logic [GAIN_FRAC-1:0] GAIN_HALF = GAIN_FRAC'(1) << (GAIN_FRAC - 1);

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_LUMA_ONLY_MODE = 2'd0,
		CFG_COLOR_IMAGE    = 2'd1,
		CFG_STRETCH_OFFSET = 2'd2,
		CFG_STRETCH_GAIN   = 2'd3
	} cfg_index_t;

	typedef struct packed {
		logic [PIX_W-1:0] red_in;
		logic [PIX_W-1:0] green_in;
		logic [PIX_W-1:0] blue_in;
		logic             end_of_frame;
	} pix_in_t;

	typedef struct packed {
		logic [PIX_W-1:0] red_out;
		logic [PIX_W-1:0] green_out;
		logic [PIX_W-1:0] blue_out;
		logic             frame_last;
	} pix_out_t;

endpackage
`default_nettype wire

// File: rtl/core/luma_contrast_stretch_pixel.sv
`default_nettype none
// ----------------------------------------------------------------------------
// luma_contrast_stretch_pixel - linear contrast stretch of one RGB pixel
// Stretches R, G and B separately, or only BT.601 full-range luma with a
// YCbCr round trip; grayscale pixels travel in the red field.
// ----------------------------------------------------------------------------
// Usage: one pixel enters per clock unless a stall at result_ready has filled
// the pipeline (throughput one pixel per cycle). Each pixel passes through the
// six-stage datapath: luma products, luma sum and chroma differences, chroma
// and stretch products, rounding and clamping, inverse-conversion products,
// and the final sums with rounding and clamping, which form the result
// register. Each stage holds only while the stage after it is full and
// stalled, so bubbles close up and pixel_ready stays high while the result
// register waits, as long as the pipeline has a free slot. The mode bits are
// sampled as a pixel enters and travel with it; offset and gain are read
// live at the stretch-product stage. Write registers only while no pixel is
// in flight.
// ----------------------------------------------------------------------------
module luma_contrast_stretch_pixel #(
	parameter int unsigned COEF_FRAC_BITS = 16
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	// pixel channel
	input  wire logic                                   pixel_valid,
	output logic                                        pixel_ready,
	input  wire lcs_pkg::pix_in_t                       pixel,
	// result channel
	output logic                                        result_valid,
	input  wire logic                                   result_ready,
	output lcs_pkg::pix_out_t                           result,
	// configuration write port
	input  wire logic                                   cfg_wr_en,
	input  wire logic [lcs_pkg::CFG_INDEX_W-1:0]        cfg_index,
	input  wire logic [lcs_pkg::CFG_DATA_W-1:0]         cfg_data
);

	// ------------------------------------------------------------------
	// Coefficients, unsigned Q0.F (Q1.F for the inverse scales), each but KG
	// rounded to nearest from its exact decimal ratio; KG is one minus KR and KB.
	// ------------------------------------------------------------------
	localparam int unsigned F  = COEF_FRAC_BITS;
	localparam int unsigned CW = F + 1;        // coefficient width
	localparam int unsigned PW = CW + 8;       // coefficient x 8-bit sample
	localparam int unsigned SW = PW + 2;       // three-term luma sum
	localparam int unsigned MW = F + 11;       // signed inverse product
	localparam int unsigned RW = F + 13;       // signed inverse sum

	localparam longint unsigned ONE_L = 64'd1 << F;
	localparam longint unsigned KR_L  = ((64'd299 << F) + 64'd500) / 64'd1000;
	localparam longint unsigned KB_L  = ((64'd114 << F) + 64'd500) / 64'd1000;
	localparam longint unsigned KG_L  = ONE_L - KR_L - KB_L;
	localparam longint unsigned CCB_L = ((64'd500 << F) + 64'd443) / 64'd886;
	localparam longint unsigned CCR_L = ((64'd500 << F) + 64'd350) / 64'd701;
	localparam longint unsigned CRV_L = ((64'd1402 << F) + 64'd500) / 64'd1000;
	localparam longint unsigned CBU_L = ((64'd1772 << F) + 64'd500) / 64'd1000;
	localparam longint unsigned CGU_L = ((64'd202008 << F) + 64'd293500) / 64'd587000;
	localparam longint unsigned CGV_L = ((64'd419198 << F) + 64'd293500) / 64'd587000;

	localparam logic [CW-1:0] KR  = CW'(KR_L);
	localparam logic [CW-1:0] KG  = CW'(KG_L);
	localparam logic [CW-1:0] KB  = CW'(KB_L);
	localparam logic [CW-1:0] CCB = CW'(CCB_L);
	localparam logic [CW-1:0] CCR = CW'(CCR_L);
	localparam logic [CW-1:0] CRV = CW'(CRV_L);
	localparam logic [CW-1:0] CBU = CW'(CBU_L);
	localparam logic [CW-1:0] CGU = CW'(CGU_L);
	localparam logic [CW-1:0] CGV = CW'(CGV_L);

	localparam logic [SW-1:0] HALF_S = SW'(1) << (F - 1);
	localparam logic [PW:0]   HALF_P = (PW + 1)'(1) << (F - 1);
	localparam logic [RW-1:0] HALF_R = RW'(1) << (F - 1);

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic                             luma_only_mode_q;
	logic                             color_image_q;
	logic [lcs_pkg::PIX_W-1:0]        stretch_offset_q;
	logic [lcs_pkg::GAIN_W-1:0]       stretch_gain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			luma_only_mode_q <= 1'b0;
			color_image_q    <= 1'b1;
			stretch_offset_q <= '0;
			stretch_gain_q   <= lcs_pkg::GAIN_W'(1024);
		end else if (cfg_wr_en) begin
			unique case (lcs_pkg::cfg_index_t'(cfg_index))
				lcs_pkg::CFG_LUMA_ONLY_MODE: luma_only_mode_q <= cfg_data[0];
				lcs_pkg::CFG_COLOR_IMAGE:    color_image_q    <= cfg_data[0];
				lcs_pkg::CFG_STRETCH_OFFSET: stretch_offset_q <= cfg_data[7:0];
				lcs_pkg::CFG_STRETCH_GAIN:   stretch_gain_q   <= cfg_data[17:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Flow control: a stage loads when it is empty or its successor loads.
	// ------------------------------------------------------------------
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6;

	assign en_s6 = !v_s6 || result_ready;
	assign en_s5 = !v_s5 || en_s6;
	assign en_s4 = !v_s4 || en_s5;
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;

	assign pixel_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= pixel_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
			if (en_s6) v_s6 <= v_s5;
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: luma products; sample the mode with the pixel.
	// ------------------------------------------------------------------
	logic                      luma_s1, color_s1, eof_s1;
	logic [7:0]                r_s1, g_s1, b_s1;
	logic [PW-1:0]             pr_s1, pg_s1, pb_s1;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			luma_s1  <= luma_only_mode_q && color_image_q;
			color_s1 <= color_image_q;
			eof_s1   <= pixel.end_of_frame;
			r_s1     <= pixel.red_in;
			g_s1     <= pixel.green_in;
			b_s1     <= pixel.blue_in;
			pr_s1    <= PW'(KR) * PW'(pixel.red_in);
			pg_s1    <= PW'(KG) * PW'(pixel.green_in);
			pb_s1    <= PW'(KB) * PW'(pixel.blue_in);
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: luma sum rounded half up, chroma differences as sign and
	// magnitude. Coefficients sum to one, so Y never exceeds 255.
	// ------------------------------------------------------------------
	logic [SW-1:0] ysum;
	logic [7:0]    y_c;
	logic [8:0]    db_c, dr_c;

	always_comb begin
		ysum = SW'(pr_s1) + SW'(pg_s1) + SW'(pb_s1) + HALF_S;
		y_c  = ysum[F+7:F];
		db_c = {1'b0, b_s1} - {1'b0, y_c};
		dr_c = {1'b0, r_s1} - {1'b0, y_c};
	end

	logic       luma_s2, color_s2, eof_s2;
	logic [7:0] lane0_s2, g_s2, b_s2;
	logic [7:0] dbm_s2, drm_s2;
	logic       dbn_s2, drn_s2;

	always_ff @(posedge clk) begin
		if (en_s2) begin
			luma_s2  <= luma_s1;
			color_s2 <= color_s1;
			eof_s2   <= eof_s1;
			// luma mode stretches Y in the red lane
			lane0_s2 <= luma_s1 ? y_c : r_s1;
			g_s2     <= g_s1;
			b_s2     <= b_s1;
			dbn_s2   <= db_c[8];
			drn_s2   <= dr_c[8];
			dbm_s2   <= db_c[8] ? 8'(-db_c) : db_c[7:0];
			drm_s2   <= dr_c[8] ? 8'(-dr_c) : dr_c[7:0];
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: chroma scale products and stretch products per lane.
	// ------------------------------------------------------------------
	logic [8:0] d0_c, d1_c, d2_c;

	always_comb begin
		d0_c = {1'b0, lane0_s2} - {1'b0, stretch_offset_q};
		d1_c = {1'b0, g_s2}     - {1'b0, stretch_offset_q};
		d2_c = {1'b0, b_s2}     - {1'b0, stretch_offset_q};
	end

	localparam int unsigned SPW = lcs_pkg::GAIN_W + 8;

	logic           luma_s3, color_s3, eof_s3;
	logic [PW-1:0]  pcb_s3, pcr_s3;
	logic           cbn_s3, crn_s3;
	logic [SPW-1:0] sp0_s3, sp1_s3, sp2_s3;
	logic           pos0_s3, pos1_s3, pos2_s3;

	always_ff @(posedge clk) begin
		if (en_s3) begin
			luma_s3  <= luma_s2;
			color_s3 <= color_s2;
			eof_s3   <= eof_s2;
			pcb_s3   <= PW'(CCB) * PW'(dbm_s2);
			pcr_s3   <= PW'(CCR) * PW'(drm_s2);
			cbn_s3   <= dbn_s2;
			crn_s3   <= drn_s2;
			// zero or negative difference stretches to black
			pos0_s3  <= !d0_c[8] && (d0_c != 9'd0);
			pos1_s3  <= !d1_c[8] && (d1_c != 9'd0);
			pos2_s3  <= !d2_c[8] && (d2_c != 9'd0);
			sp0_s3   <= SPW'(d0_c[7:0]) * SPW'(stretch_gain_q);
			sp1_s3   <= SPW'(d1_c[7:0]) * SPW'(stretch_gain_q);
			sp2_s3   <= SPW'(d2_c[7:0]) * SPW'(stretch_gain_q);
		end
	end

	// ------------------------------------------------------------------
	// Stage 4: round chroma half away from zero and clamp to -128..127;
	// round the stretch products and saturate to 255.
	// ------------------------------------------------------------------
	logic [PW:0]         cbsum, crsum;
	logic [8:0]          cbm, crm;
	logic signed [8:0]   cb_c, cr_c;
	logic [SPW:0]        q0, q1, q2;
	logic [7:0]          st0_c, st1_c, st2_c;

	always_comb begin
		cbsum = (PW + 1)'(pcb_s3) + HALF_P;
		crsum = (PW + 1)'(pcr_s3) + HALF_P;
		cbm   = cbsum[F+8:F];
		crm   = crsum[F+8:F];
		if (cbn_s3) begin
			cb_c = (cbm > 9'd128) ? -9'sd128 : -$signed(cbm);
		end else begin
			cb_c = (cbm > 9'd127) ? 9'sd127 : $signed(cbm);
		end
		if (crn_s3) begin
			cr_c = (crm > 9'd128) ? -9'sd128 : -$signed(crm);
		end else begin
			cr_c = (crm > 9'd127) ? 9'sd127 : $signed(crm);
		end

		q0 = (SPW + 1)'(sp0_s3) + (SPW + 1)'(lcs_pkg::GAIN_HALF);
		q1 = (SPW + 1)'(sp1_s3) + (SPW + 1)'(lcs_pkg::GAIN_HALF);
		q2 = (SPW + 1)'(sp2_s3) + (SPW + 1)'(lcs_pkg::GAIN_HALF);
		st0_c = !pos0_s3 ? 8'd0 : (q0[SPW:10] > (SPW - 9)'(255)) ? 8'd255 : q0[17:10];
		st1_c = !pos1_s3 ? 8'd0 : (q1[SPW:10] > (SPW - 9)'(255)) ? 8'd255 : q1[17:10];
		st2_c = !pos2_s3 ? 8'd0 : (q2[SPW:10] > (SPW - 9)'(255)) ? 8'd255 : q2[17:10];
	end

	logic                luma_s4, color_s4, eof_s4;
	logic signed [8:0]   cb_s4, cr_s4;
	logic [7:0]          st0_s4, st1_s4, st2_s4;

	always_ff @(posedge clk) begin
		if (en_s4) begin
			luma_s4  <= luma_s3;
			color_s4 <= color_s3;
			eof_s4   <= eof_s3;
			cb_s4    <= cb_c;
			cr_s4    <= cr_c;
			st0_s4   <= st0_c;
			st1_s4   <= st1_c;
			st2_s4   <= st2_c;
		end
	end

	// ------------------------------------------------------------------
	// Stage 5: inverse conversion products.
	// ------------------------------------------------------------------
	logic                luma_s5, color_s5, eof_s5;
	logic signed [MW-1:0] prv_s5, pbu_s5, pgu_s5, pgv_s5;
	logic [7:0]          st0_s5, st1_s5, st2_s5;

	always_ff @(posedge clk) begin
		if (en_s5) begin
			luma_s5  <= luma_s4;
			color_s5 <= color_s4;
			eof_s5   <= eof_s4;
			prv_s5   <= $signed({1'b0, CRV}) * cr_s4;
			pbu_s5   <= $signed({1'b0, CBU}) * cb_s4;
			pgu_s5   <= $signed({1'b0, CGU}) * cb_s4;
			pgv_s5   <= $signed({1'b0, CGV}) * cr_s4;
			st0_s5   <= st0_s4;
			st1_s5   <= st1_s4;
			st2_s5   <= st2_s4;
		end
	end

	// ------------------------------------------------------------------
	// Stage 6: sum with the stretched luma, round half away from zero,
	// clamp, and select by mode. Negative sums clamp to zero, so only the
	// non-negative rounding is needed. This stage is the result register.
	// ------------------------------------------------------------------
	logic signed [RW-1:0] yq, rsum, bsum, gsum;
	logic [RW-1:0]        rt, bt, gt;
	logic [7:0]           ro_c, go_c, bo_c;

	always_comb begin
		yq   = $signed(RW'({st0_s5, F'(0)}));
		rsum = yq + RW'(prv_s5);
		bsum = yq + RW'(pbu_s5);
		gsum = yq - RW'(pgu_s5) - RW'(pgv_s5);
		rt   = $unsigned(rsum) + HALF_R;
		bt   = $unsigned(bsum) + HALF_R;
		gt   = $unsigned(gsum) + HALF_R;
		ro_c = rsum[RW-1] ? 8'd0 : (rt[RW-2:F] > (RW - 1 - F)'(255)) ? 8'd255 : rt[F+7:F];
		bo_c = bsum[RW-1] ? 8'd0 : (bt[RW-2:F] > (RW - 1 - F)'(255)) ? 8'd255 : bt[F+7:F];
		go_c = gsum[RW-1] ? 8'd0 : (gt[RW-2:F] > (RW - 1 - F)'(255)) ? 8'd255 : gt[F+7:F];
	end

	logic       color_s6;
	lcs_pkg::pix_out_t res_s6;

	always_ff @(posedge clk) begin
		if (en_s6) begin
			color_s6          <= color_s5;
			res_s6.frame_last <= eof_s5;
			if (luma_s5) begin
				res_s6.red_out   <= ro_c;
				res_s6.green_out <= go_c;
				res_s6.blue_out  <= bo_c;
			end else begin
				// per-channel stretch; grayscale drops green and blue
				res_s6.red_out   <= st0_s5;
				res_s6.green_out <= color_s5 ? st1_s5 : 8'd0;
				res_s6.blue_out  <= color_s5 ? st2_s5 : 8'd0;
			end
		end
	end

	assign result_valid = v_s6;
	assign result       = res_s6;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_gray_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s6 && !color_s6) |-> (result.green_out == 8'd0 && result.blue_out == 8'd0))
		else $error("grayscale result carries green or blue");

	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(pixel_valid && pixel_ready) |=> v_s1)
		else $error("accepted pixel lost at stage 1");

	a_hold_stage5: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s5 && !en_s6) |=> v_s5)
		else $error("stalled stage 5 pixel dropped");

endmodule
`default_nettype wire
